[hdl/tkct_pkg.sv]
// Shared types and constants for the top-K cost tracker.
// Holds the item and result structs and the controller/datapath interface.
// No dependencies.
package tkct_pkg;

    localparam int ID_W                = 32;
    localparam int COST_W              = 24;
    localparam int RANK_W              = 3;
    localparam int READ_LIMIT          = 8;
    localparam int TRACKED_ENTRIES_DEF = 8;

    localparam logic [1:0] CMD_MERGE = 2'd0;
    localparam logic [1:0] CMD_CLEAR = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    typedef struct packed {
        logic [1:0]        command;
        logic [ID_W-1:0]   entry_id;
        logic [COST_W-1:0] entry_bits;
    } t_in_item;

    typedef struct packed {
        logic [RANK_W-1:0] rank;
        logic [ID_W-1:0]   ranked_id;
        logic [COST_W-1:0] ranked_bits;
        logic              last;
    } t_out_item;

    typedef struct packed {
        logic load_merge;
        logic insert;
        logic clear;
        logic read_init;
        logic read_step;
    } t_dp_cmd;

    typedef struct packed {
        logic read_last;
    } t_dp_status;

endpackage

[hdl/tkct_ctrl.sv]
// Controller state machine of the top-K cost tracker.
// Decodes accepted items into datapath commands; depends on tkct_pkg.
module tkct_ctrl import tkct_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  t_in_item   i_item,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_INSERT = 3'b010,
        S_READ   = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_item.command)
                        CMD_MERGE: begin
                            if (i_item.entry_bits != '0) begin
                                o_cmd.load_merge = 1'b1;
                                n_state          = S_INSERT;
                            end
                        end
                        CMD_CLEAR: begin
                            o_cmd.clear = 1'b1;
                        end
                        CMD_READ: begin
                            o_cmd.read_init = 1'b1;
                            n_state         = S_READ;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_INSERT: begin
                o_cmd.insert = 1'b1;
                n_state      = S_IDLE;
            end
            S_READ: begin
                o_cmd.read_step = 1'b1;
                if (i_status.read_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[hdl/tkct_datapath.sv]
// Datapath of the top-K cost tracker: ranked table, match, insert and read-out.
// Driven by tkct_ctrl commands; depends on tkct_pkg.
module tkct_datapath import tkct_pkg::*; #(
    parameter int TRACKED_ENTRIES = TRACKED_ENTRIES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_in_item   i_item,
    input  t_dp_cmd    i_cmd,
    output t_dp_status o_status,
    output logic       o_res_valid,
    output t_out_item  o_result
);

    localparam int IW     = (TRACKED_ENTRIES > 1) ? $clog2(TRACKED_ENTRIES) : 1;
    localparam int READ_N = (TRACKED_ENTRIES < READ_LIMIT) ? TRACKED_ENTRIES : READ_LIMIT;

    logic [ID_W-1:0]   r_ids   [TRACKED_ENTRIES];
    logic [COST_W-1:0] r_costs [TRACKED_ENTRIES];
    logic [ID_W-1:0]   n_ids   [TRACKED_ENTRIES];
    logic [COST_W-1:0] n_costs [TRACKED_ENTRIES];

    logic [IW-1:0]     r_pos;
    logic [ID_W-1:0]   r_new_id;
    logic [COST_W-1:0] r_new_cost;
    logic              r_apply;

    logic [IW-1:0]     r_rd_idx;
    logic              r_res_valid;
    t_out_item         r_result;

    logic [TRACKED_ENTRIES-1:0] hit_oh;
    logic                       any_hit;
    logic [IW-1:0]              hit_pos;
    logic [COST_W-1:0]          old_cost;
    logic [COST_W-1:0]          tail_cost;
    logic [COST_W-1:0]          merged_cost;
    logic                       merge_apply;
    logic [TRACKED_ENTRIES-1:0] above;
    logic [TRACKED_ENTRIES-1:0] above_prev;
    logic                       rd_last;

    // Match stage: first held entry with the same id, else the lowest rank.
    always_comb begin
        hit_oh   = '0;
        any_hit  = 1'b0;
        hit_pos  = IW'(TRACKED_ENTRIES - 1);
        old_cost = '0;
        for (int k = 0; k < TRACKED_ENTRIES; k++) begin
            if ((r_ids[k] == i_item.entry_id) && !any_hit) begin
                hit_oh[k] = 1'b1;
                hit_pos   = IW'(k);
                any_hit   = 1'b1;
            end
        end
        for (int k = 0; k < TRACKED_ENTRIES; k++) begin
            if (hit_oh[k]) begin
                old_cost = old_cost | r_costs[k];
            end
        end
    end

    assign tail_cost = r_costs[TRACKED_ENTRIES-1];

    always_comb begin
        if (any_hit) begin
            merged_cost = (i_item.entry_bits > old_cost) ? i_item.entry_bits : old_cost;
            merge_apply = 1'b1;
        end else begin
            merged_cost = i_item.entry_bits;
            merge_apply = (tail_cost == '0) || (i_item.entry_bits > tail_cost);
        end
    end

    // Insert stage: the changed entry can only move toward rank zero.
    always_comb begin
        above      = '0;
        above_prev = '0;
        for (int k = 0; k < TRACKED_ENTRIES; k++) begin
            if (IW'(k) < r_pos) begin
                above[k] = (r_new_cost > r_costs[k]) ||
                           ((r_new_cost == r_costs[k]) && (r_new_id < r_ids[k]));
            end
        end
        for (int k = 1; k < TRACKED_ENTRIES; k++) begin
            above_prev[k] = above[k-1];
        end
    end

    always_comb begin
        for (int k = 0; k < TRACKED_ENTRIES; k++) begin
            n_ids[k]   = r_ids[k];
            n_costs[k] = r_costs[k];
        end
        for (int k = 1; k < TRACKED_ENTRIES; k++) begin
            if ((IW'(k) <= r_pos) && above_prev[k]) begin
                n_ids[k]   = r_ids[k-1];
                n_costs[k] = r_costs[k-1];
            end
        end
        for (int k = 0; k < TRACKED_ENTRIES; k++) begin
            if ((IW'(k) <= r_pos) && !above_prev[k] && (above[k] || (IW'(k) == r_pos))) begin
                n_ids[k]   = r_new_id;
                n_costs[k] = r_new_cost;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            for (int k = 0; k < TRACKED_ENTRIES; k++) begin
                r_ids[k]   <= '0;
                r_costs[k] <= '0;
            end
        end else if (i_cmd.insert && r_apply) begin
            for (int k = 0; k < TRACKED_ENTRIES; k++) begin
                r_ids[k]   <= n_ids[k];
                r_costs[k] <= n_costs[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_apply <= 1'b0;
        end else if (i_cmd.load_merge) begin
            r_apply <= merge_apply;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_merge) begin
            r_pos      <= hit_pos;
            r_new_id   <= i_item.entry_id;
            r_new_cost <= merged_cost;
        end
    end

    // Read-out: one ranked entry per cycle into the result register.
    assign rd_last            = (r_rd_idx == IW'(READ_N - 1));
    assign o_status.read_last = rd_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_idx    <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= i_cmd.read_step;
            if (i_cmd.read_init) begin
                r_rd_idx <= '0;
            end else if (i_cmd.read_step) begin
                r_rd_idx <= r_rd_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.read_step) begin
            r_result.rank        <= RANK_W'(r_rd_idx);
            r_result.ranked_id   <= r_ids[r_rd_idx];
            r_result.ranked_bits <= r_costs[r_rd_idx];
            r_result.last        <= rd_last;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_result    = r_result;

endmodule

[hdl/top_k_cost_tracker_core.sv]
// Top level of the top-K cost tracker: controller and datapath.
// Instantiates tkct_ctrl and tkct_datapath; depends on tkct_pkg.
//
// An item is taken when start is high and busy is low. A merge finds the
// matching entry in the cycle it is taken and keeps busy high in the cycle
// after, while the ranked table is shifted to insert it. Merges with zero
// cost, clears and unused commands finish in the cycle they are taken. A read
// keeps busy high while it steps through the first min(TRACKED_ENTRIES, 8)
// ranked entries and delivers one result per cycle, so the last result is
// shown in the first cycle after busy falls. Each result is shown for exactly
// one cycle with o_res_valid; the receiver cannot stall the stream.
module top_k_cost_tracker_core import tkct_pkg::*; #(
    parameter int TRACKED_ENTRIES = TRACKED_ENTRIES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_item  i_item,
    output logic      o_res_valid,
    output t_out_item o_result
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    tkct_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .i_status (dp_status),
        .o_cmd    (dp_cmd)
    );

    tkct_datapath #(
        .TRACKED_ENTRIES (TRACKED_ENTRIES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .i_cmd       (dp_cmd),
        .o_status    (dp_status),
        .o_res_valid (o_res_valid),
        .o_result    (o_result)
    );

endmodule
